>>> rtl/mvsm_pkg.sv
// Shared types and constants of the stereo voice mixer.
package mvsm_pkg;

  localparam int unsigned CNT_W  = 7;   // active voice count, holds up to 127
  localparam int unsigned BUSY_W = 6;   // reported count, saturated
  localparam logic [16:0] UNITY  = 17'd32768;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN_L,
    ST_GAIN_R,
    ST_GAIN_W,
    ST_FIND,
    ST_VCHK,
    ST_MUL_L,
    ST_MUL_R,
    ST_SUM,
    ST_DONE
  } state_e;

  // Accepted word handed to the sequencer
  typedef struct packed {
    logic               go;
    logic [1:0]         op;
    logic [15:0]        addr;
    logic [16:0]        len;
    logic [15:0]        vol;
    logic signed [15:0] pan;
  } cmd_t;

  // Finished frame handed to the output register
  typedef struct packed {
    logic               valid;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [5:0]         busy;
  } res_t;

  // One voice table entry; gains are worked out once at start
  typedef struct packed {
    logic [15:0] start;
    logic [16:0] pos;
    logic [16:0] len;
    logic [15:0] gain_l;
    logic [15:0] gain_r;
  } voice_t;

endpackage

>>> rtl/mvsm_mul_unit.sv
// Shared signed 17x17 multiplier with registered product.
module mvsm_mul_unit (
  input  logic               clk_i,
  input  logic signed [16:0] a_i,
  input  logic signed [16:0] b_i,
  output logic signed [33:0] prod_o
);

  logic signed [33:0] prod_q;

  // one product per cycle, available the cycle after the operands
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/mvsm_sample_mem.sv
// Stereo frame memory: one write port, one registered read port.
module mvsm_sample_mem #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [2**ADDR_W];
  logic [31:0] rdata_q;

  // frames: left sample in the low half, right in the high half
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mvsm_seq.sv
// Sequencer: voice table, voice allocation and per-voice mixing over the shared multiplier.
module mvsm_seq #(
  parameter int unsigned VOICES             = 32,
  parameter int unsigned FRAME_ADDRESS_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mvsm_pkg::cmd_t                cmd_i,
  output logic                          idle_o,
  input  logic                          out_free_i,
  output mvsm_pkg::res_t                res_o,
  output logic signed [16:0]            mul_a_o,
  output logic signed [16:0]            mul_b_o,
  input  logic signed [33:0]            mul_prod_i,
  output logic                          smp_re_o,
  output logic [FRAME_ADDRESS_BITS-1:0] smp_raddr_o,
  input  logic [31:0]                   smp_rdata_i
);

  localparam int unsigned IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned ACC_W = 33 + $clog2(VOICES);
  localparam int unsigned SUM_W = (FRAME_ADDRESS_BITS > 18) ? FRAME_ADDRESS_BITS : 18;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

  mvsm_pkg::state_e          state_q, state_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [VOICES-1:0]         active_q, active_d;
  logic signed [ACC_W-1:0]   acc_l_q, acc_l_d;
  logic signed [ACC_W-1:0]   acc_r_q, acc_r_d;
  logic                      pend_q, pend_d;
  logic [mvsm_pkg::CNT_W-1:0] busy_q, busy_d;
  logic [15:0]               gain_l_q, gain_l_d;
  logic [15:0]               gain_r_q, gain_r_d;
  logic [15:0]               start_q, start_d;
  logic [16:0]               len_q, len_d;
  logic [15:0]               vol_q, vol_d;
  logic signed [15:0]        pan_q, pan_d;

  mvsm_pkg::voice_t          vmem_q [VOICES];
  mvsm_pkg::voice_t          vrd_q;
  mvsm_pkg::voice_t          vwr_data;
  logic                      vrd_en;
  logic [IDX_W-1:0]          vrd_addr;
  logic                      vwr_en;

  logic [16:0]               pan_pos;
  logic [16:0]               pan_neg;
  logic                      play;
  logic                      retire;
  logic                      is_last;
  logic [16:0]               next_pos;
  logic [SUM_W-1:0]          fsum;
  logic signed [ACC_W-1:0]   prod_ext;

  // floor by 2^15 and clamp to the Q1.15 range
  function automatic logic signed [15:0] sat_q15(input logic signed [ACC_W-1:0] acc);
    logic ovf;
    ovf = !((&acc[ACC_W-1:30]) || !(|acc[ACC_W-1:30]));
    if (ovf) begin
      sat_q15 = acc[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_q15 = acc[30:15];
    end
  endfunction

  // pan split: positive pan cuts left, negative pan cuts right
  assign pan_pos  = pan_q[15] ? 17'd0 : {1'b0, pan_q};
  assign pan_neg  = pan_q[15] ? (17'd0 - {pan_q[15], pan_q}) : 17'd0;

  assign is_last  = (idx_q == LAST_IDX);
  assign play     = active_q[idx_q] && (vrd_q.pos < vrd_q.len);
  assign next_pos = vrd_q.pos + 17'd1;
  assign fsum     = SUM_W'(vrd_q.start) + SUM_W'(vrd_q.pos);
  assign smp_raddr_o = fsum[FRAME_ADDRESS_BITS-1:0];
  assign prod_ext = ACC_W'(mul_prod_i);

  assign idle_o   = (state_q == mvsm_pkg::ST_IDLE);

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    active_d    = active_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    pend_d      = pend_q;
    busy_d      = busy_q;
    gain_l_d    = gain_l_q;
    gain_r_d    = gain_r_q;
    start_d     = start_q;
    len_d       = len_q;
    vol_d       = vol_q;
    pan_d       = pan_q;
    mul_a_o     = '0;
    mul_b_o     = '0;
    vrd_en      = 1'b0;
    vrd_addr    = idx_q;
    vwr_en      = 1'b0;
    vwr_data    = vrd_q;
    smp_re_o    = 1'b0;
    retire      = 1'b0;
    // result fields follow the accumulators
    res_o.valid = 1'b0;
    res_o.left  = sat_q15(acc_l_q);
    res_o.right = sat_q15(acc_r_q);
    res_o.busy  = (busy_q > 7'd63) ? 6'd63 : busy_q[mvsm_pkg::BUSY_W-1:0];

    case (state_q)
      mvsm_pkg::ST_IDLE: begin
        if (cmd_i.go) begin
          case (cmd_i.op)
            mvsm_pkg::OP_START: begin
              start_d = cmd_i.addr;
              len_d   = cmd_i.len;
              vol_d   = cmd_i.vol;
              pan_d   = cmd_i.pan;
              state_d = mvsm_pkg::ST_GAIN_L;
            end
            mvsm_pkg::OP_TICK: begin
              idx_d    = '0;
              vrd_en   = 1'b1;
              vrd_addr = '0;
              acc_l_d  = '0;
              acc_r_d  = '0;
              busy_d   = '0;
              pend_d   = 1'b0;
              state_d  = mvsm_pkg::ST_VCHK;
            end
            default: begin
              state_d = mvsm_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // gain = (vol * (32768 - p)) >> 15, left then right
      mvsm_pkg::ST_GAIN_L: begin
        mul_a_o = {1'b0, vol_q};
        mul_b_o = mvsm_pkg::UNITY - pan_pos;
        state_d = mvsm_pkg::ST_GAIN_R;
      end
      mvsm_pkg::ST_GAIN_R: begin
        gain_l_d = mul_prod_i[30:15];
        mul_a_o  = {1'b0, vol_q};
        mul_b_o  = mvsm_pkg::UNITY - pan_neg;
        state_d  = mvsm_pkg::ST_GAIN_W;
      end
      mvsm_pkg::ST_GAIN_W: begin
        gain_r_d = mul_prod_i[30:15];
        idx_d    = '0;
        state_d  = mvsm_pkg::ST_FIND;
      end

      // scan for the lowest free voice; drop the start if none
      mvsm_pkg::ST_FIND: begin
        if (!active_q[idx_q]) begin
          vwr_en          = 1'b1;
          vwr_data.start  = start_q;
          vwr_data.pos    = '0;
          vwr_data.len    = len_q;
          vwr_data.gain_l = gain_l_q;
          vwr_data.gain_r = gain_r_q;
          active_d[idx_q] = 1'b1;
          state_d         = mvsm_pkg::ST_IDLE;
        end else if (is_last) begin
          state_d = mvsm_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // per voice: fold in pending right product, advance, retire
      mvsm_pkg::ST_VCHK: begin
        if (pend_q) begin
          acc_r_d = acc_r_q + prod_ext;
        end
        pend_d = 1'b0;
        if (active_q[idx_q]) begin
          if (play) begin
            vwr_en       = 1'b1;
            vwr_data.pos = next_pos;
            smp_re_o     = 1'b1;
            retire       = (next_pos >= vrd_q.len);
          end else begin
            retire = 1'b1;
          end
          if (retire) begin
            active_d[idx_q] = 1'b0;
          end else begin
            busy_d = busy_q + 7'd1;
          end
        end
        if (play) begin
          state_d = mvsm_pkg::ST_MUL_L;
        end else if (is_last) begin
          state_d = mvsm_pkg::ST_SUM;
        end else begin
          idx_d    = idx_q + 1'b1;
          vrd_en   = 1'b1;
          vrd_addr = idx_q + 1'b1;
        end
      end

      mvsm_pkg::ST_MUL_L: begin
        mul_a_o = {smp_rdata_i[15], smp_rdata_i[15:0]};
        mul_b_o = {1'b0, vrd_q.gain_l};
        state_d = mvsm_pkg::ST_MUL_R;
      end

      mvsm_pkg::ST_MUL_R: begin
        acc_l_d = acc_l_q + prod_ext;
        mul_a_o = {smp_rdata_i[31], smp_rdata_i[31:16]};
        mul_b_o = {1'b0, vrd_q.gain_r};
        pend_d  = 1'b1;
        if (is_last) begin
          state_d = mvsm_pkg::ST_SUM;
        end else begin
          idx_d    = idx_q + 1'b1;
          vrd_en   = 1'b1;
          vrd_addr = idx_q + 1'b1;
          state_d  = mvsm_pkg::ST_VCHK;
        end
      end

      mvsm_pkg::ST_SUM: begin
        if (pend_q) begin
          acc_r_d = acc_r_q + prod_ext;
        end
        pend_d  = 1'b0;
        state_d = mvsm_pkg::ST_DONE;
      end

      // hand the frame over once the output register is free
      mvsm_pkg::ST_DONE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          state_d     = mvsm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mvsm_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mvsm_pkg::ST_IDLE;
      idx_q    <= '0;
      active_q <= '0;
      pend_q   <= 1'b0;
      busy_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      active_q <= active_d;
      pend_q   <= pend_d;
      busy_q   <= busy_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_l_q  <= acc_l_d;
    acc_r_q  <= acc_r_d;
    gain_l_q <= gain_l_d;
    gain_r_q <= gain_r_d;
    start_q  <= start_d;
    len_q    <= len_d;
    vol_q    <= vol_d;
    pan_q    <= pan_d;
  end

  // voice table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (vwr_en) begin
      vmem_q[idx_q] <= vwr_data;
    end
    if (vrd_en) begin
      vrd_q <= vmem_q[vrd_addr];
    end
  end

  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q <= mvsm_pkg::CNT_W'(VOICES))
    else $error("active voice count exceeds voice count");

  a_pend_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == mvsm_pkg::ST_VCHK || state_q == mvsm_pkg::ST_SUM))
    else $error("right product pending outside mix loop");

  a_mul_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvsm_pkg::ST_MUL_L) |-> $past(active_q[idx_q]))
    else $error("mixing an inactive voice");

  a_find_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvsm_pkg::ST_FIND && vwr_en) |-> !active_q[idx_q])
    else $error("start overwrote a busy voice");

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("frame issued while output register full");

endmodule

>>> rtl/multi_voice_stereo_sample_mixer.sv
// Multi-voice stereo sample mixer: top level with input handshake and output register.
//
// Input channel (in_valid_i/in_ready_o) takes one word per item:
//   write: stores {right, left} at the frame address, done in the accept cycle.
//   start: computes both pan gains on the shared multiplier, then scans the
//          voice table one voice per cycle for the lowest free one.
//          Dropped silently if every voice is busy.
//   tick:  walks all VOICES entries; an idle voice takes only the table check,
//          a playing voice the table check and the left and right multiply on
//          the one multiplier. Unused operation code 3 is dropped.
// in_ready_o is high only while the sequencer is idle; one item at a time.
// Output channel (out_valid_o/out_ready_i) is a single register; a finished
// frame waits there while the next item is accepted. A tick whose frame finds
// the register still full holds in its last state until the receiver takes it.
// Reset clears all voices and empties the output register; sample memory keeps
// whatever it held and must be written before it is played.
module multi_voice_stereo_sample_mixer #(
  parameter int unsigned VOICES             = 32,
  parameter int unsigned FRAME_ADDRESS_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic [16:0]        sound_length_i,
  input  logic [15:0]        volume_i,
  input  logic signed [15:0] pan_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic [5:0]         voices_busy_o
);

  localparam int unsigned WA_W = (FRAME_ADDRESS_BITS > 16) ? FRAME_ADDRESS_BITS : 16;

  logic                          accept;
  logic                          seq_idle;
  logic                          out_free;
  mvsm_pkg::cmd_t                cmd;
  mvsm_pkg::res_t                res;
  logic signed [16:0]            mul_a;
  logic signed [16:0]            mul_b;
  logic signed [33:0]            mul_prod;
  logic                          smp_we;
  logic [WA_W-1:0]               waddr_ext;
  logic                          smp_re;
  logic [FRAME_ADDRESS_BITS-1:0] smp_raddr;
  logic [31:0]                   smp_rdata;

  logic                          out_valid_q, out_valid_d;
  logic signed [15:0]            left_q;
  logic signed [15:0]            right_q;
  logic [5:0]                    busy_q;

  // input handshake
  assign in_ready_o = seq_idle;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd.go   = accept;
  assign cmd.op   = operation_i;
  assign cmd.addr = address_i;
  assign cmd.len  = sound_length_i;
  assign cmd.vol  = volume_i;
  assign cmd.pan  = pan_i;

  // frame writes go straight to memory
  assign smp_we    = accept && (operation_i == mvsm_pkg::OP_WRITE);
  assign waddr_ext = WA_W'(address_i);

  mvsm_sample_mem #(
    .ADDR_W (FRAME_ADDRESS_BITS)
  ) u_sample_mem (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (waddr_ext[FRAME_ADDRESS_BITS-1:0]),
    .wdata_i ({right_sample_i, left_sample_i}),
    .re_i    (smp_re),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  mvsm_mul_unit u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  mvsm_seq #(
    .VOICES             (VOICES),
    .FRAME_ADDRESS_BITS (FRAME_ADDRESS_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idle_o      (seq_idle),
    .out_free_i  (out_free),
    .res_o       (res),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_prod_i  (mul_prod),
    .smp_re_o    (smp_re),
    .smp_raddr_o (smp_raddr),
    .smp_rdata_i (smp_rdata)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      left_q  <= res.left;
      right_q <= res.right;
      busy_q  <= res.busy;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_out_o    = left_q;
  assign right_out_o   = right_q;
  assign voices_busy_o = busy_q;

endmodule
